// ===== design/assert_macros.svh =====
// Assertion macros used by the FIR convolution controller.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
// Uses the clk and arst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BFC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BFC_ASSERT(lbl, prop, msg)
`define BFC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/bfc_pkg.sv =====
// Shared constants, register indexes and the controller command struct
// for the block FIR convolution. No dependencies.
package bfc_pkg;

	localparam int MAX_TAPS_DEF  = 16;
	localparam int MAX_BLOCK_DEF = 32;

	localparam int SAMPLE_W    = 16;
	localparam int TAP_IDX_W   = 4;
	localparam int PROD_W      = 2 * SAMPLE_W;
	localparam int RESULT_W    = 36;
	localparam int TAP_COUNT_W = 5;
	localparam int BLOCK_LEN_W = 6;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 40;
	localparam int VALUE_LSB = TAP_IDX_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 5'd16;
	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RST = 6'd32;

	localparam logic OP_COEF   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic coef_wr;
		logic push_sample;
		logic clear_hist;
		logic push_zero;
		logic acc_clr;
		logic mac_issue;
		logic out_load;
		logic out_last;
	} bfc_cmd_t;

endpackage

// ===== design/block_fir_convolution.sv =====
// Top level of the block FIR convolution: configuration registers, stream
// ports, controller and datapath. Uses bfc_pkg, bfc_ctrl and bfc_datapath.
//
//   Port group  Direction  Contents
//   s_t*        in         tuser: op; tdata: tap_index [3:0], value [19:4]
//   m_t*        out        tdata: result [35:0]; tlast: last output of a block
//   cfg_*       in         cfg_index selects tap_count (0) or block_length (1)
//
// A coefficient transaction is written to the store as it is accepted. A sample
// transaction runs acceptance, one multiply-accumulate per tap through the single
// multiplier, a flush that drains the product register and a write that loads the
// output register. A block's last sample adds taps-1 zero-input tail outputs.
// Reset clears the coefficient store, the sample history and the position.
// A stalled output register holds the next result back in its write step.
module block_fir_convolution import bfc_pkg::*; #(
	parameter int MAX_TAPS  = MAX_TAPS_DEF,
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // tap_index, value
	input  logic                  s_tuser,   // op
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // result
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [TAP_COUNT_W-1:0] tap_count_q;
	logic [BLOCK_LEN_W-1:0] block_length_q;
	bfc_cmd_t               cmd;
	logic [TAP_W-1:0]       mac_idx;
	logic [RESULT_W-1:0]    result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q    <= TAP_COUNT_RST;
			block_length_q <= BLOCK_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TAP_COUNT: begin
					tap_count_q <= cfg_data[TAP_COUNT_W-1:0];
				end
				REG_BLOCK_LENGTH: begin
					block_length_q <= cfg_data[BLOCK_LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	bfc_ctrl #(
		.MAX_TAPS  (MAX_TAPS),
		.MAX_BLOCK (MAX_BLOCK)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_op         (s_tuser),
		.tap_count    (tap_count_q),
		.block_length (block_length_q),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.cmd          (cmd),
		.mac_idx      (mac_idx)
	);

	bfc_datapath #(
		.MAX_TAPS (MAX_TAPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mac_idx   (mac_idx),
		.tap_index (s_tdata[TAP_IDX_W-1:0]),
		.value     (s_tdata[VALUE_LSB +: SAMPLE_W]),
		.result    (result),
		.last      (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, result};

endmodule

// ===== design/bfc_datapath.sv =====
// Datapath: coefficient store, sample history shift line, registered
// multiplier, accumulator and output register. Uses bfc_pkg.
module bfc_datapath import bfc_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF,
	localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bfc_cmd_t                   cmd,
	input  logic [TAP_W-1:0]           mac_idx,
	input  logic [TAP_IDX_W-1:0]       tap_index,
	input  logic signed [SAMPLE_W-1:0] value,
	output logic [RESULT_W-1:0]        result,
	output logic                       last
);

	logic signed [SAMPLE_W-1:0] coef_q [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_q [MAX_TAPS];
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       pv_s1;
	logic signed [RESULT_W-1:0] acc_q;
	logic [RESULT_W-1:0]        result_q;
	logic                       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cmd.coef_wr && (int'(tap_index) < MAX_TAPS)) begin
			coef_q[TAP_W'(tap_index)] <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.push_sample || cmd.push_zero) begin
			for (int i = MAX_TAPS - 1; i > 0; i--) begin
				hist_q[i] <= cmd.clear_hist ? '0 : hist_q[i-1];
			end
			hist_q[0] <= cmd.push_sample ? value : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mac_issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= hist_q[mac_idx] * coef_q[mac_idx];
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + {{(RESULT_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
		if (cmd.out_load) begin
			result_q <= acc_q;
			last_q   <= cmd.out_last;
		end
	end

	assign result = result_q;
	assign last   = last_q;

endmodule

// ===== design/bfc_ctrl.sv =====
// Controller: sequences sample pushes, tap-by-tap accumulation, tail outputs
// and the output handshake. Uses bfc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bfc_ctrl import bfc_pkg::*; #(
	parameter int MAX_TAPS  = MAX_TAPS_DEF,
	parameter int MAX_BLOCK = MAX_BLOCK_DEF,
	localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic                   s_op,
	input  logic [TAP_COUNT_W-1:0] tap_count,
	input  logic [BLOCK_LEN_W-1:0] block_length,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output bfc_cmd_t               cmd,
	output logic [TAP_W-1:0]       mac_idx
);

	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int POS_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CMP_W = ((POS_W > BLOCK_LEN_W) ? POS_W : BLOCK_LEN_W) + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [TAP_W-1:0]   k_q, k_d;
	logic [TAP_W-1:0]   rem_q, rem_d;
	logic               ends_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [CNT_W-1:0]   taps;
	logic [CNT_W-1:0]   taps_m1;
	logic [TAP_W-1:0]   last_k;
	logic [CMP_W-1:0]   len;
	logic               ends;
	logic               accept;
	logic               slot_free;

	always_comb begin
		if (tap_count == '0) begin
			taps = CNT_W'(1);
		end else if (int'(tap_count) > MAX_TAPS) begin
			taps = CNT_W'(MAX_TAPS);
		end else begin
			taps = CNT_W'(tap_count);
		end
		if (block_length == '0) begin
			len = CMP_W'(1);
		end else if (int'(block_length) > MAX_BLOCK) begin
			len = CMP_W'(MAX_BLOCK);
		end else begin
			len = CMP_W'(block_length);
		end
	end

	assign taps_m1   = taps - CNT_W'(1);
	assign last_k    = TAP_W'(taps_m1);
	assign ends      = (CMP_W'(pos_q) + CMP_W'(1)) >= len;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign mac_idx   = k_q;
	assign m_tvalid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		rem_d   = rem_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_op == OP_COEF) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.push_sample = 1'b1;
						cmd.clear_hist  = (pos_q == '0);
						cmd.acc_clr     = 1'b1;
						k_d             = '0;
						rem_d           = ends ? last_k : '0;
						state_d         = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (k_q == last_k) begin
					state_d = ST_FLUSH;
				end else begin
					k_d = k_q + TAP_W'(1);
				end
			end
			ST_FLUSH: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = ends_q && (rem_q == '0);
					if (rem_q != '0) begin
						cmd.push_zero = 1'b1;
						cmd.acc_clr   = 1'b1;
						rem_d         = rem_q - TAP_W'(1);
						k_d           = '0;
						state_d       = ST_MAC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			rem_q       <= '0;
			ends_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			rem_q   <= rem_d;
			if (cmd.push_sample) begin
				ends_q <= ends;
				pos_q  <= ends ? '0 : pos_q + POS_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BFC_ASSERT(a_sample_starts_mac, (accept && s_op == OP_SAMPLE) |=> (state_q == ST_MAC), "sample transaction did not start accumulation")
	`BFC_ASSERT(a_tail_only_at_end, (rem_q != '0) |-> ends_q, "tail outputs pending outside a block end")
	`BFC_ASSERT(a_tap_in_range, (state_q == ST_MAC) |-> (k_q <= last_k), "tap counter beyond taps in use")
	`BFC_ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_q && !m_tready, "pending result overwritten")

endmodule
